// ===== sv/pfe_pkg.sv =====
// Shared types and constants for the palette fade engine.
// Used by the step unit, the top level, the checker and the testbench; depends on nothing.
package pfe_pkg;

  // Channel and field widths fixed by the interface.
  localparam int CH_W   = 8;
  localparam int IDX_W  = 6;
  localparam int RNG_W  = 7;
  localparam int CNT_W  = 5;
  localparam int MODE_W = 3;
  localparam int CMD_W  = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WR_CUR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_TGT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd5;

  // Fade mode codes.
  localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_IN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLASH_IN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH_OUT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_ENTRY = 2'd0;
  localparam logic [1:0] CFG_LAST_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SECOND_BANK = 2'd2;

  // Color step and limits.
  localparam logic [CH_W-1:0]  STEP_SIZE  = 8'd32;
  localparam logic [CH_W-1:0]  WHITE      = 8'd224;
  localparam logic [IDX_W-1:0] FULL_LAST  = 6'd63;
  localparam logic [IDX_W-1:0] FULL_START = 6'd0;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              bank;
    logic [IDX_W-1:0]  entry_index;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    logic [MODE_W-1:0] fade_mode;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic              done_res;
    logic [MODE_W-1:0] active_mode;
  } out_word_t;

endpackage

// ===== sv/pfe_mem.sv =====
// Palette store: one write port and one registered read port with enable.
// Standalone; no package dependency.
module pfe_mem #(
  parameter int AW = 7,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while the enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pfe_step.sv =====
// Shared step unit: moves one palette entry one step of 32 in one channel.
// Depends on pfe_pkg for the color type, mode codes and step constants.
module pfe_step (
  input  pfe_pkg::rgb_t              cur,
  input  pfe_pkg::rgb_t              tgt,
  input  logic [pfe_pkg::MODE_W-1:0] kind,
  output pfe_pkg::rgb_t              nxt
);

  logic                      c_r, c_g, c_b;
  logic                      up;
  logic                      sel_r, sel_g, sel_b;
  logic [pfe_pkg::CH_W-1:0]  opnd;
  logic [pfe_pkg::CH_W-1:0]  sum;

  // Per-channel conditions and direction for the active fade kind.
  always_comb begin
    c_r = 1'b0;
    c_g = 1'b0;
    c_b = 1'b0;
    up  = 1'b0;
    case (kind)
      pfe_pkg::MODE_FADE_IN: begin
        c_r = tgt.red   > cur.red;
        c_g = tgt.green > cur.green;
        c_b = tgt.blue  > cur.blue;
        up  = 1'b1;
      end
      pfe_pkg::MODE_FLASH_IN: begin
        c_r = tgt.red   < cur.red;
        c_g = tgt.green < cur.green;
        c_b = tgt.blue  < cur.blue;
      end
      pfe_pkg::MODE_FADE_OUT: begin
        c_r = cur.red   != '0;
        c_g = cur.green != '0;
        c_b = cur.blue  != '0;
      end
      pfe_pkg::MODE_FLASH_OUT: begin
        c_r = cur.red   != pfe_pkg::WHITE;
        c_g = cur.green != pfe_pkg::WHITE;
        c_b = cur.blue  != pfe_pkg::WHITE;
        up  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Priority: the fade-in kinds look at blue first, the out kinds at red first.
  always_comb begin
    if (kind == pfe_pkg::MODE_FADE_IN || kind == pfe_pkg::MODE_FLASH_IN) begin
      sel_b = c_b;
      sel_g = !c_b && c_g;
      sel_r = !c_b && !c_g && c_r;
    end else begin
      sel_r = c_r;
      sel_g = !c_r && c_g;
      sel_b = !c_r && !c_g && c_b;
    end
  end

  // One adder serves whichever channel was picked; it wraps modulo 256.
  always_comb begin
    if (sel_r) begin
      opnd = cur.red;
    end else if (sel_g) begin
      opnd = cur.green;
    end else begin
      opnd = cur.blue;
    end
    sum = up ? (opnd + pfe_pkg::STEP_SIZE) : (opnd - pfe_pkg::STEP_SIZE);
  end

  always_comb begin
    nxt = cur;
    if (sel_r) begin
      nxt.red = sum;
    end
    if (sel_g) begin
      nxt.green = sum;
    end
    if (sel_b) begin
      nxt.blue = sum;
    end
  end

endmodule

// ===== sv/palette_fade_engine.sv =====
// Top level of the palette fade engine: command sequencer, palette stores
// and step unit. Depends on pfe_pkg, pfe_mem and pfe_step.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid, in_ready, in_data        | in
//   result  | out_valid, out_ready, out_data     | out
//   config  | cfg_valid, cfg_ready, cfg_index,   | in
//           | cfg_data                           |
//
// A write, read, stop, idle tick or non-filling start goes from idle to
// done, which registers its result once the output is free. An active tick
// sweeps (last_offset + 1) entries per bank stepped, one entry per cycle
// through the read-modify-write of the current store, then passes drain and
// done. A fade-in or flash-in start fills bank 0 the same way. Reset is
// synchronous, active low; the stores keep their contents.
// A stalled result holds in the output register while the next word is taken.
module palette_fade_engine #(
  parameter int ENTRIES    = 64,
  parameter int FADE_STEPS = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfe_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfe_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int AW = IW + 1;
  localparam logic [8:0] ENT_LIM = 9'(ENTRIES);
  localparam logic [pfe_pkg::CNT_W-1:0] STEPS_LIM = pfe_pkg::CNT_W'(FADE_STEPS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [pfe_pkg::IDX_W-1:0]     start_r, last_r;
  logic                          second_bank_r;
  logic [pfe_pkg::MODE_W-1:0]    mode_r;
  logic [pfe_pkg::CNT_W-1:0]     fc_r;
  logic                          sw_bank_r, sw_two_r, sw_fill_r, sw_white_r;
  logic [pfe_pkg::IDX_W-1:0]     sw_idx_r;
  logic                          b_valid_r, b_act_r;
  logic [AW-1:0]                 b_addr_r;
  logic                          is_read_r, rd_ok_r, done_r;
  logic                          out_valid_r;
  pfe_pkg::out_word_t            out_data_r;

  logic                          in_acc, cfg_acc;
  logic                          host_ok, mode_active, start_ok, start_fill;
  logic                          out_kind, sweep_last, slot_free;
  logic [AW-1:0]                 host_addr, sw_addr;
  logic [pfe_pkg::RNG_W-1:0]     sw_entry;
  logic                          sw_act;
  logic [pfe_pkg::CNT_W-1:0]     fc_inc;
  logic                          fc_wrap;
  pfe_pkg::rgb_t                 host_rgb, cur_rdata, tgt_rdata, step_rgb;
  pfe_pkg::rgb_t                 fill_rgb, cur_wdata;
  logic                          cur_we, tgt_we, cur_re, tgt_re;
  logic [AW-1:0]                 cur_waddr, cur_raddr;

  // Handshakes.
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // Decode of the incoming word and of the current mode.
  assign host_ok    = 9'(in_data.entry_index) < ENT_LIM;
  assign host_addr  = {in_data.bank, IW'(in_data.entry_index)};
  assign host_rgb   = {in_data.red_in, in_data.green_in, in_data.blue_in};
  assign mode_active = (mode_r >= pfe_pkg::MODE_FADE_IN) &&
                       (mode_r <= pfe_pkg::MODE_FLASH_OUT);
  assign out_kind   = (mode_r == pfe_pkg::MODE_FADE_OUT) ||
                      (mode_r == pfe_pkg::MODE_FLASH_OUT);
  assign start_ok   = (in_data.fade_mode >= pfe_pkg::MODE_FADE_IN) &&
                      (in_data.fade_mode <= pfe_pkg::MODE_FLASH_OUT);
  assign start_fill = (in_data.fade_mode == pfe_pkg::MODE_FADE_IN) ||
                      (in_data.fade_mode == pfe_pkg::MODE_FLASH_IN);
  assign fc_inc     = fc_r + 1'b1;
  assign fc_wrap    = fc_inc >= STEPS_LIM;

  // Sweep address: entries past the end of the store are walked but not written.
  assign sw_entry   = {1'b0, start_r} + {1'b0, sw_idx_r};
  assign sw_act     = 9'(sw_entry) < ENT_LIM;
  assign sw_addr    = {sw_bank_r, IW'(sw_entry)};
  assign sweep_last = (sw_idx_r == last_r) && (sw_bank_r || !sw_two_r);

  // Store ports: host access while idle, the sweep pipeline otherwise.
  assign fill_rgb  = sw_white_r ? {pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE} : '0;
  assign cur_we    = b_valid_r ? b_act_r : (in_acc && host_ok &&
                     in_data.cmd == pfe_pkg::CMD_WR_CUR);
  assign cur_waddr = b_valid_r ? b_addr_r : host_addr;
  assign cur_wdata = b_valid_r ? (sw_fill_r ? fill_rgb : step_rgb) : host_rgb;
  assign cur_re    = (state_r == S_SWEEP) || (in_acc && in_data.cmd == pfe_pkg::CMD_READ);
  assign cur_raddr = (state_r == S_SWEEP) ? sw_addr : host_addr;
  assign tgt_we    = in_acc && host_ok && in_data.cmd == pfe_pkg::CMD_WR_TGT;
  assign tgt_re    = (state_r == S_SWEEP);

  pfe_mem #(.AW(AW), .DW(3 * pfe_pkg::CH_W)) u_cur (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  pfe_mem #(.AW(AW), .DW(3 * pfe_pkg::CH_W)) u_tgt (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (host_addr),
    .wdata (host_rgb),
    .re    (tgt_re),
    .raddr (sw_addr),
    .rdata (tgt_rdata)
  );

  pfe_step u_step (
    .cur  (cur_rdata),
    .tgt  (tgt_rdata),
    .kind (mode_r),
    .nxt  (step_rgb)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_data.cmd == pfe_pkg::CMD_TICK && mode_active) ||
              (in_data.cmd == pfe_pkg::CMD_START && start_fill)) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, mode, frame count, registers, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= pfe_pkg::MODE_NONE;
      fc_r          <= '0;
      start_r       <= pfe_pkg::FULL_START;
      last_r        <= pfe_pkg::FULL_LAST;
      second_bank_r <= 1'b1;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      b_valid_r <= (state_r == S_SWEEP);

      if (cfg_acc) begin
        case (cfg_index)
          pfe_pkg::CFG_START_ENTRY: start_r       <= cfg_data;
          pfe_pkg::CFG_LAST_OFFSET: last_r        <= cfg_data;
          pfe_pkg::CFG_SECOND_BANK: second_bank_r <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        case (in_data.cmd)
          pfe_pkg::CMD_START: begin
            if (start_ok) begin
              if (in_data.fade_mode != pfe_pkg::MODE_FADE_IN) begin
                start_r <= pfe_pkg::FULL_START;
                last_r  <= pfe_pkg::FULL_LAST;
              end
              fc_r   <= '0;
              mode_r <= in_data.fade_mode;
            end
          end
          pfe_pkg::CMD_TICK: begin
            if (mode_active) begin
              fc_r <= fc_wrap ? '0 : fc_inc;
            end
          end
          pfe_pkg::CMD_STOP: begin
            mode_r <= pfe_pkg::MODE_NONE;
          end
          default: begin
          end
        endcase
      end

      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sweep counters, pipeline stage and pending result fields.
  always_ff @(posedge clk) begin
    b_act_r  <= sw_act;
    b_addr_r <= sw_addr;
    if (in_acc) begin
      sw_idx_r   <= '0;
      sw_bank_r  <= 1'b0;
      sw_fill_r  <= (in_data.cmd == pfe_pkg::CMD_START);
      sw_white_r <= (in_data.fade_mode == pfe_pkg::MODE_FLASH_IN);
      sw_two_r   <= (in_data.cmd == pfe_pkg::CMD_TICK) && (out_kind || second_bank_r);
      is_read_r  <= (in_data.cmd == pfe_pkg::CMD_READ);
      rd_ok_r    <= host_ok;
      done_r     <= (in_data.cmd == pfe_pkg::CMD_TICK) && (!mode_active || fc_wrap);
    end else if (state_r == S_SWEEP) begin
      if (sw_idx_r == last_r) begin
        sw_idx_r  <= '0;
        sw_bank_r <= 1'b1;
      end else begin
        sw_idx_r <= sw_idx_r + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && slot_free) begin
      out_data_r.red_out     <= (is_read_r && rd_ok_r) ? cur_rdata.red   : '0;
      out_data_r.green_out   <= (is_read_r && rd_ok_r) ? cur_rdata.green : '0;
      out_data_r.blue_out    <= (is_read_r && rd_ok_r) ? cur_rdata.blue  : '0;
      out_data_r.done_res    <= done_r;
      out_data_r.active_mode <= mode_r;
    end
  end

endmodule

// ===== sv/pfe_checker.sv =====
// Port-level checks for the palette fade engine, bound to the top level.
// Depends on pfe_pkg and palette_fade_engine.
module pfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pfe_pkg::out_word_t out_data
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A waiting result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // The sequencer works on one word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  // Colors come only with reads, done only with ticks.
  a_done_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      out_data.red_out == '0 && out_data.green_out == '0 && out_data.blue_out == '0)
    else $error("done reported together with a color");

  // The reported mode is never beyond flash-out.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.active_mode <= pfe_pkg::MODE_FLASH_OUT)
    else $error("reported mode out of range");

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/palette_fade_engine_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for palette_fade_engine: random and directed command
// words, an in-line palette predictor and a field-by-field result checker.
// Depends on pfe_pkg and the palette_fade_engine RTL.
module palette_fade_engine_tb;

  localparam int ENTRIES      = 64;
  localparam int FADE_STEPS   = 22;
  localparam int RANDOM_WORDS = 1400;
  localparam int PHASE_WORDS  = 220;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 200;
  localparam int SHOWN_ERRORS = 50;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pfe_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pfe_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = pfe_pkg::CFG_START_ENTRY;
  logic [5:0]         cfg_data = '0;

  // Shadow copy of the palette stores, mode, frame count and registers.
  pfe_pkg::rgb_t              shadow_cur [2*ENTRIES];
  pfe_pkg::rgb_t              shadow_tgt [2*ENTRIES];
  logic [pfe_pkg::MODE_W-1:0] run_mode = pfe_pkg::MODE_NONE;
  logic [pfe_pkg::CNT_W-1:0]  frame_cnt = '0;
  logic [pfe_pkg::IDX_W-1:0]  fade_first = pfe_pkg::FULL_START;
  logic [pfe_pkg::IDX_W-1:0]  fade_span = pfe_pkg::FULL_LAST;
  logic                       bank1_fades = 1'b1;

  pfe_pkg::in_word_t  cmd_backlog [$];
  pfe_pkg::out_word_t due_results [$];
  int words_queued = 0;
  int words_in = 0;
  int results_taken = 0;
  int mismatches = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int quiet_cycles = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  bit held_off = 1'b0;

  palette_fade_engine #(
    .ENTRIES(ENTRIES),
    .FADE_STEPS(FADE_STEPS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // One frame step of one entry: a single channel moves by 32, wrapping at 8 bits.
  function automatic pfe_pkg::rgb_t step_color(pfe_pkg::rgb_t c, pfe_pkg::rgb_t t,
                                               logic [pfe_pkg::MODE_W-1:0] m);
    pfe_pkg::rgb_t n;
    n = c;
    case (m)
      pfe_pkg::MODE_FADE_IN: begin
        if (t.blue > c.blue) n.blue = c.blue + pfe_pkg::STEP_SIZE;
        else if (t.green > c.green) n.green = c.green + pfe_pkg::STEP_SIZE;
        else if (t.red > c.red) n.red = c.red + pfe_pkg::STEP_SIZE;
      end
      pfe_pkg::MODE_FLASH_IN: begin
        if (t.blue < c.blue) n.blue = c.blue - pfe_pkg::STEP_SIZE;
        else if (t.green < c.green) n.green = c.green - pfe_pkg::STEP_SIZE;
        else if (t.red < c.red) n.red = c.red - pfe_pkg::STEP_SIZE;
      end
      pfe_pkg::MODE_FADE_OUT: begin
        if (c.red != 0) n.red = c.red - pfe_pkg::STEP_SIZE;
        else if (c.green != 0) n.green = c.green - pfe_pkg::STEP_SIZE;
        else if (c.blue != 0) n.blue = c.blue - pfe_pkg::STEP_SIZE;
      end
      default: begin
        if (c.red != pfe_pkg::WHITE) n.red = c.red + pfe_pkg::STEP_SIZE;
        else if (c.green != pfe_pkg::WHITE) n.green = c.green + pfe_pkg::STEP_SIZE;
        else if (c.blue != pfe_pkg::WHITE) n.blue = c.blue + pfe_pkg::STEP_SIZE;
      end
    endcase
    return n;
  endfunction

  // Step every in-range entry of one bank; entries past the store are skipped.
  function automatic void sweep_bank(int bk);
    int e;
    for (int i = 0; i <= fade_span; i++) begin
      e = fade_first + i;
      if (e < ENTRIES)
        shadow_cur[bk*ENTRIES+e] = step_color(shadow_cur[bk*ENTRIES+e],
                                              shadow_tgt[bk*ENTRIES+e], run_mode);
    end
  endfunction

  function automatic void fill_bank0(pfe_pkg::rgb_t col);
    int e;
    for (int i = 0; i <= fade_span; i++) begin
      e = fade_first + i;
      if (e < ENTRIES) shadow_cur[e] = col;
    end
  endfunction

  // Apply one command word to the shadow state and return the result it causes.
  function automatic pfe_pkg::out_word_t predict_palette_cmd(pfe_pkg::in_word_t w);
    pfe_pkg::out_word_t r;
    pfe_pkg::rgb_t      rd;
    int                 addr;
    r = '0;
    rd = '0;
    addr = int'(w.bank) * ENTRIES + int'(w.entry_index);
    case (w.cmd)
      pfe_pkg::CMD_WR_CUR: shadow_cur[addr] = {w.red_in, w.green_in, w.blue_in};
      pfe_pkg::CMD_WR_TGT: shadow_tgt[addr] = {w.red_in, w.green_in, w.blue_in};
      pfe_pkg::CMD_READ:   rd = shadow_cur[addr];
      pfe_pkg::CMD_START: begin
        if (w.fade_mode >= pfe_pkg::MODE_FADE_IN &&
            w.fade_mode <= pfe_pkg::MODE_FLASH_OUT) begin
          if (w.fade_mode != pfe_pkg::MODE_FADE_IN) begin
            fade_first = pfe_pkg::FULL_START;
            fade_span = pfe_pkg::FULL_LAST;
          end
          if (w.fade_mode == pfe_pkg::MODE_FADE_IN) fill_bank0('0);
          else if (w.fade_mode == pfe_pkg::MODE_FLASH_IN)
            fill_bank0({pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE});
          frame_cnt = '0;
          run_mode = w.fade_mode;
        end
      end
      pfe_pkg::CMD_TICK: begin
        if (run_mode >= pfe_pkg::MODE_FADE_IN &&
            run_mode <= pfe_pkg::MODE_FLASH_OUT) begin
          sweep_bank(0);
          if (run_mode == pfe_pkg::MODE_FADE_OUT || run_mode == pfe_pkg::MODE_FLASH_OUT ||
              bank1_fades)
            sweep_bank(1);
          frame_cnt = frame_cnt + 1'b1;
          if (frame_cnt >= FADE_STEPS) begin
            frame_cnt = '0;
            r.done_res = 1'b1;
          end
        end else begin
          r.done_res = 1'b1;
        end
      end
      pfe_pkg::CMD_STOP: run_mode = pfe_pkg::MODE_NONE;
      default: ;
    endcase
    r.red_out = rd.red;
    r.green_out = rd.green;
    r.blue_out = rd.blue;
    r.active_mode = run_mode;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display("mismatch at result %0d: %s got %0h want %0h", results_taken, what, got, want);
  endtask

  // Sender: takes words from the backlog, predicts each one as it is accepted.
  always @(posedge clk) begin : cmd_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(predict_palette_cmd(in_data));
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_data <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          send_wait = send_steady ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    pfe_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", 32'(out_data), '0);
        end else begin
          want = due_results.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch("red_out", 32'(out_data.red_out), 32'(want.red_out));
          if (out_data.green_out !== want.green_out)
            report_mismatch("green_out", 32'(out_data.green_out), 32'(want.green_out));
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue_out", 32'(out_data.blue_out), 32'(want.blue_out));
          if (out_data.done_res !== want.done_res)
            report_mismatch("done_res", 32'(out_data.done_res), 32'(want.done_res));
          if (out_data.active_mode !== want.active_mode)
            report_mismatch("active_mode", 32'(out_data.active_mode),
                            32'(want.active_mode));
        end
        results_taken++;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 9);
        // One long hold-off while words keep arriving, so the block backs up.
        if (!held_off && results_taken >= HOLD_AT && cmd_backlog.size() > 20) begin
          held_off = 1'b1;
          recv_wait = HOLD_CYCLES;
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic pfe_pkg::in_word_t any_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(pfe_pkg::in_word_t)-1:0];
  endfunction

  // Mostly multiples of 32 so fades settle, with some arbitrary channel values.
  function automatic logic [pfe_pkg::CH_W-1:0] pick_chan();
    logic [pfe_pkg::CH_W-1:0] v;
    if ($urandom_range(0, 3) == 0) v = pfe_pkg::CH_W'($urandom_range(0, 255));
    else v = {3'($urandom_range(0, 7)), 5'b0};
    return v;
  endfunction

  function automatic logic [pfe_pkg::MODE_W-1:0] pick_fade();
    logic [pfe_pkg::MODE_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = pfe_pkg::MODE_FADE_IN;
      1: m = pfe_pkg::MODE_FADE_OUT;
      2: m = pfe_pkg::MODE_FLASH_IN;
      default: m = pfe_pkg::MODE_FLASH_OUT;
    endcase
    return m;
  endfunction

  function automatic pfe_pkg::in_word_t write_word(logic [pfe_pkg::CMD_W-1:0] c, logic b,
                                                   logic [pfe_pkg::IDX_W-1:0] idx);
    pfe_pkg::in_word_t w;
    w = any_word();
    w.cmd = c;
    w.bank = b;
    w.entry_index = idx;
    w.red_in = pick_chan();
    w.green_in = pick_chan();
    w.blue_in = pick_chan();
    return w;
  endfunction

  task automatic queue_word(pfe_pkg::in_word_t w);
    cmd_backlog.push_back(w);
    words_queued++;
  endtask

  task automatic queue_cmd(logic [pfe_pkg::CMD_W-1:0] c, logic b,
                           logic [pfe_pkg::IDX_W-1:0] idx, pfe_pkg::rgb_t col,
                           logic [pfe_pkg::MODE_W-1:0] fm);
    pfe_pkg::in_word_t w;
    w.cmd = c;
    w.bank = b;
    w.entry_index = idx;
    w.red_in = col.red;
    w.green_in = col.green;
    w.blue_in = col.blue;
    w.fade_mode = fm;
    queue_word(w);
  endtask

  task automatic queue_with_cmd(logic [pfe_pkg::CMD_W-1:0] c);
    pfe_pkg::in_word_t w;
    w = any_word();
    w.cmd = c;
    queue_word(w);
  endtask

  // A random write of either store to a random entry of a random bank.
  task automatic queue_rand_write();
    queue_word(write_word($urandom_range(0, 1) ? pfe_pkg::CMD_WR_TGT : pfe_pkg::CMD_WR_CUR,
                          1'($urandom_range(0, 1)),
                          pfe_pkg::IDX_W'($urandom_range(0, 63))));
  endtask

  // A start, a run of ticks with reads and writes mixed in, and sometimes a stop.
  task automatic queue_fade_run();
    pfe_pkg::in_word_t w;
    int n_ticks;
    repeat ($urandom_range(0, 4))
      queue_rand_write();
    w = any_word();
    w.cmd = pfe_pkg::CMD_START;
    w.fade_mode = pick_fade();
    queue_word(w);
    n_ticks = $urandom_range(0, 1) ? $urandom_range(FADE_STEPS, FADE_STEPS + 6)
                                   : $urandom_range(1, FADE_STEPS - 1);
    repeat (n_ticks) begin
      queue_with_cmd(pfe_pkg::CMD_TICK);
      case ($urandom_range(0, 9))
        0, 1, 2: queue_with_cmd(pfe_pkg::CMD_READ);
        3: queue_rand_write();
        default: ;
      endcase
    end
    if ($urandom_range(0, 1)) queue_with_cmd(pfe_pkg::CMD_STOP);
  endtask

  task automatic wait_drained();
    while (words_in != words_queued || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pfe_pkg::CFG_START_ENTRY: fade_first = val;
      pfe_pkg::CFG_LAST_OFFSET: fade_span = val;
      pfe_pkg::CFG_SECOND_BANK: bank1_fades = val[0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int phase_end;
    int stop_at;
    phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill both stores so that no fade or read touches an unwritten entry.
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < ENTRIES; i++) begin
        queue_word(write_word(pfe_pkg::CMD_WR_CUR, 1'(b), pfe_pkg::IDX_W'(i)));
        queue_word(write_word(pfe_pkg::CMD_WR_TGT, 1'(b), pfe_pkg::IDX_W'(i)));
      end

    // Directed words under the reset register values.
    queue_cmd(pfe_pkg::CMD_WR_CUR, 1'b0, 6'd0, {8'hFF, 8'hFF, 8'hFF}, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_WR_CUR, 1'b1, 6'd63, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_WR_TGT, 1'b1, 6'd63, {8'hFF, 8'h00, 8'hFF}, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_WR_TGT, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_READ, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_READ, 1'b1, 6'd63, '0, pfe_pkg::MODE_NONE);
    // Tick while idle reports done.
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    // Starts with an unknown mode leave everything alone.
    queue_cmd(pfe_pkg::CMD_START, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    for (int m = pfe_pkg::MODE_FLASH_OUT + 1; m < 2**pfe_pkg::MODE_W; m++)
      queue_cmd(pfe_pkg::CMD_START, 1'b1, 6'd63, '1, pfe_pkg::MODE_W'(m));
    // Unknown commands are ignored.
    for (int c = pfe_pkg::CMD_STOP + 1; c < 2**pfe_pkg::CMD_W; c++)
      queue_cmd(pfe_pkg::CMD_W'(c), 1'b0, 6'd0, '1, pfe_pkg::MODE_FADE_IN);
    queue_cmd(pfe_pkg::CMD_START, 1'b0, 6'd0, '0, pfe_pkg::MODE_FADE_IN);
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_READ, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_START, 1'b0, 6'd0, '0, pfe_pkg::MODE_FADE_OUT);
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_START, 1'b0, 6'd0, '0, pfe_pkg::MODE_FLASH_IN);
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_READ, 1'b1, 6'd63, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_START, 1'b0, 6'd0, '0, pfe_pkg::MODE_FLASH_OUT);
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_STOP, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_TICK, 1'b0, 6'd0, '0, pfe_pkg::MODE_NONE);
    queue_cmd(pfe_pkg::CMD_READ, 1'b0, 6'd63, '0, pfe_pkg::MODE_NONE);

    // Random phases, each under its own register setting, written while idle.
    stop_at = words_queued + RANDOM_WORDS;
    while (words_queued < stop_at) begin
      wait_drained();
      case (phase % 6)
        0: begin
          write_reg(pfe_pkg::CFG_START_ENTRY, 6'd63);
          write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'd63);
          write_reg(pfe_pkg::CFG_SECOND_BANK, 6'd0);
        end
        1: begin
          write_reg(pfe_pkg::CFG_START_ENTRY, 6'd0);
          write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'd0);
          write_reg(pfe_pkg::CFG_SECOND_BANK, 6'h3F);
        end
        2: begin
          write_reg(pfe_pkg::CFG_START_ENTRY, pfe_pkg::FULL_START);
          write_reg(pfe_pkg::CFG_LAST_OFFSET, pfe_pkg::FULL_LAST);
          write_reg(pfe_pkg::CFG_SECOND_BANK, 6'd1);
        end
        4: begin
          write_reg(pfe_pkg::CFG_START_ENTRY, 6'd32);
          write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'($urandom_range(0, 63)));
          write_reg(pfe_pkg::CFG_SECOND_BANK, 6'h2A);
        end
        default: begin
          write_reg(pfe_pkg::CFG_START_ENTRY, 6'($urandom_range(0, 63)));
          write_reg(pfe_pkg::CFG_LAST_OFFSET, 6'($urandom_range(0, 63)));
          write_reg(pfe_pkg::CFG_SECOND_BANK, 6'($urandom_range(0, 63)));
        end
      endcase
      send_steady = (phase % 3 == 1);
      recv_steady = (phase % 3 == 2);
      @(negedge clk);
      phase_end = words_queued + PHASE_WORDS;
      while (words_queued < phase_end && words_queued < stop_at) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(2, 8)) queue_word(any_word());
        else
          queue_fade_run();
      end
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== palette_fade_engine.f =====
sv/pfe_pkg.sv
sv/pfe_mem.sv
sv/pfe_step.sv
sv/palette_fade_engine.sv
sv/pfe_checker.sv
sim/palette_fade_engine_tb.sv
